FILE: sv/lwf_pkg.sv
`timescale 1ns / 1ps

package lwf_pkg;

  // Store depth and derived widths
  localparam int MAX_WORD = 32;
  localparam int IDX_W    = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
  localparam int CNT_W    = $clog2(MAX_WORD + 1);
  localparam int LEN_W    = 6;
  localparam int CHAR_W   = 8;
  localparam int CMP_W    = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(32);

  // Delimiter bytes
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PERIOD  = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_COMMA   = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;

  function automatic logic is_delim(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c == CH_PERIOD) || (c == CH_COMMA) ||
           (c == CH_NEWLINE) || (c == CH_NUL);
  endfunction

  typedef enum logic [1:0] {
    S_IDLE,
    S_WORD,
    S_DELIM
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic store_byte;    // write input byte into the store
    logic hold_delim;    // latch input delimiter for later
    logic read_first;    // read store entry zero
    logic read_next;     // advance read index and read
    logic load_word;     // load read data into output register
    logic load_delim_in; // load input delimiter into output register
    logic load_delim_hd; // load held delimiter into output register
    logic clear_word;    // close the open word
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_delim;   // input byte is a delimiter
    logic keep_word;  // open word is non-empty, did not overflow and is within the limit
    logic last_byte;  // current read entry is the last of the word
    logic out_free;   // output register can take an item this cycle
  } sts_t;

endpackage

FILE: sv/lwf_ctrl.sv
`timescale 1ns / 1ps

module lwf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  lwf_pkg::sts_t sts_i,
  output lwf_pkg::cmd_t cmd_o
);
  import lwf_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = sts_i.out_free;
        if (in_valid_i && sts_i.out_free) begin
          if (!sts_i.in_delim) begin
            cmd_o.store_byte = 1'b1;
          end else if (sts_i.keep_word) begin
            cmd_o.hold_delim = 1'b1;
            cmd_o.read_first = 1'b1;
            state_d          = S_WORD;
          end else begin
            cmd_o.load_delim_in = 1'b1;
            cmd_o.clear_word    = 1'b1;
          end
        end
      end
      S_WORD: begin
        if (sts_i.out_free) begin
          cmd_o.load_word = 1'b1;
          if (sts_i.last_byte) begin
            state_d = S_DELIM;
          end else begin
            cmd_o.read_next = 1'b1;
          end
        end
      end
      S_DELIM: begin
        if (sts_i.out_free) begin
          cmd_o.load_delim_hd = 1'b1;
          cmd_o.clear_word    = 1'b1;
          state_d             = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

FILE: sv/lwf_dp.sv
`timescale 1ns / 1ps

module lwf_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lwf_pkg::LEN_W-1:0]   cfg_wdata_i,
  input  logic [lwf_pkg::CHAR_W-1:0]  in_char_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [lwf_pkg::CHAR_W-1:0]  out_char_o,
  output logic                        out_last_o,
  input  lwf_pkg::cmd_t               cmd_i,
  output lwf_pkg::sts_t               sts_o
);
  import lwf_pkg::*;

  logic [CHAR_W-1:0] mem_q [MAX_WORD];
  logic [CHAR_W-1:0] rd_data_q;
  logic [LEN_W-1:0]  max_len_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              ovf_q, ovf_d;
  logic [CNT_W-1:0]  rd_cnt_q, rd_cnt_d;
  logic [CNT_W-1:0]  rd_cnt_inc;
  logic [CHAR_W-1:0] delim_q;
  logic              out_valid_q, out_valid_d;
  logic [CHAR_W-1:0] out_char_q, out_char_d;
  logic              out_last_q, out_last_d;
  logic              room;
  logic              out_load;

  assign room       = cnt_q < CNT_W'(MAX_WORD);
  assign rd_cnt_inc = CNT_W'(rd_cnt_q + 1'b1);
  assign out_load   = cmd_i.load_word | cmd_i.load_delim_in | cmd_i.load_delim_hd;

  // Status toward the controller
  always_comb begin
    sts_o.in_delim  = is_delim(in_char_i);
    sts_o.keep_word = !ovf_q && (cnt_q != '0) && (CMP_W'(cnt_q) <= CMP_W'(max_len_q));
    sts_o.last_byte = (rd_cnt_inc == cnt_q);
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  // Limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= LEN_RESET;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  // Word store: write at the fill count, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_byte && room) begin
      mem_q[cnt_q[IDX_W-1:0]] <= in_char_i;
    end
    if (cmd_i.read_first) begin
      rd_data_q <= mem_q[0];
    end else if (cmd_i.read_next) begin
      rd_data_q <= mem_q[rd_cnt_inc[IDX_W-1:0]];
    end
  end

  // Word count, overflow flag and read index
  always_comb begin
    cnt_d    = cnt_q;
    ovf_d    = ovf_q;
    rd_cnt_d = rd_cnt_q;
    if (cmd_i.store_byte) begin
      if (room) begin
        cnt_d = CNT_W'(cnt_q + 1'b1);
      end else begin
        ovf_d = 1'b1;
      end
    end
    if (cmd_i.clear_word) begin
      cnt_d = '0;
      ovf_d = 1'b0;
    end
    if (cmd_i.read_first) begin
      rd_cnt_d = '0;
    end else if (cmd_i.read_next) begin
      rd_cnt_d = rd_cnt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
      rd_cnt_q <= '0;
    end else begin
      cnt_q    <= cnt_d;
      ovf_q    <= ovf_d;
      rd_cnt_q <= rd_cnt_d;
    end
  end

  // Hold the delimiter while the word drains
  always_ff @(posedge clk_i) begin
    if (cmd_i.hold_delim) begin
      delim_q <= in_char_i;
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
    if (cmd_i.load_word) begin
      out_char_d = rd_data_q;
      out_last_d = 1'b0;
    end else if (cmd_i.load_delim_in) begin
      out_char_d = in_char_i;
      out_last_d = 1'b1;
    end else if (cmd_i.load_delim_hd) begin
      out_char_d = delim_q;
      out_last_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

endmodule

FILE: sv/long_word_filter_top.sv
`timescale 1ns / 1ps
// Channel   Direction  Payload                          Accepted when
// s_axis    in         tdata[7:0] = in_char             tvalid && tready
// m_axis    out        tdata[7:0] = out_char, tlast     tvalid && tready
// cfg       in         cfg_wdata_i = max_word_length    cfg_we_i
//
// A word byte is stored and produces nothing; the block stays idle and ready while the output register is free.
// A delimiter with a kept word drains the word, one store read a cycle while the output is free,
// through the single registered read port, then the delimiter. Otherwise the delimiter goes straight out.
// Reset is asynchronous and active low; it clears the count and sets the limit to 32.
// The output register stalls the drain while m_axis_tready is low; input is taken only
// when that register is free or emptying.

module long_word_filter_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [lwf_pkg::LEN_W-1:0]  cfg_wdata_i,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,  // [7:0] in_char
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [7:0]                 m_axis_tdata,  // [7:0] out_char
  output logic                       m_axis_tlast
);
  import lwf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lwf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lwf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_char_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  // Input is taken only when the output register can take an item
  a_ready_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (!m_axis_tvalid || m_axis_tready))
    else $error("input ready while output register is blocked");

  // A pending word byte means its delimiter is still owed, so input is held off
  a_word_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready)
    else $error("input ready while a word is still draining");

  // An accepted delimiter is followed by an item in the output register: the delimiter
  // itself, or the first word byte once the store read for it is done
  a_delim_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready &&
     ((s_axis_tdata == CH_SPACE) || (s_axis_tdata == CH_PERIOD) ||
      (s_axis_tdata == CH_COMMA) || (s_axis_tdata == CH_NEWLINE) ||
      (s_axis_tdata == CH_NUL))) |-> ##[1:2] m_axis_tvalid)
    else $error("delimiter accepted without an output item");

endmodule
